[design/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define WPPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define WPPS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/wpps_pkg.sv]
// Shared types and constants of the windowed perfusion statistics block.
`timescale 1ns / 1ps

package wpps_pkg;

	localparam int unsigned FRACTION_BITS = 8;

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned SUM_W    = 32;
	localparam int unsigned COUNT_W  = 16;
	localparam int unsigned AVG_W    = 24;
	localparam int unsigned PEAK_W   = 16;
	localparam int unsigned AC_W     = 25;
	localparam int unsigned DC_W     = 27;
	localparam int unsigned PI_W     = 32;

	localparam int unsigned S_DATA_W = 48;
	localparam int unsigned M_DATA_W = 128;
	localparam int unsigned M_USER_W = 2;

	localparam int unsigned USER_VALID_BIT  = 0;
	localparam int unsigned USER_CLOSED_BIT = 1;

	localparam logic [COUNT_W-1:0] MAX_SAMPLES_PER_WINDOW = 16'd65535;
	localparam logic [TIME_W-1:0]  INTERVAL_RESET         = 32'd1000;

	localparam logic [AVG_W-1:0] AVG_MAX  = '1;
	localparam int               AC_MAX   = 33554431;
	localparam int               DC_MAX   = 67108863;
	localparam int               DC_MIN   = -67108864;
	localparam logic [PI_W-1:0]  PI_MAX   = 32'h7FFF_FFFF;
	localparam logic [PI_W-1:0]  PI_SCALE = 32'd100;

	localparam int unsigned QUEUE_DEPTH = 2;

	// One classified request handed from the front to the back.
	typedef struct packed {
		logic               closed;
		logic               latch;
		logic [SUM_W-1:0]   sum;
		logic [COUNT_W-1:0] count;
		logic [PEAK_W-1:0]  peak;
	} cmd_t;

endpackage

[design/windowed_pulse_perfusion_stats.sv]
// Top level of the windowed average, peak and perfusion index block.
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// s_*      in         s_tvalid / s_tready  s_tdata: sample, timestamp_ms
// m_*      out        m_tvalid / m_tready  m_tdata: average, peak, ac, dc, index;
//                                          m_tuser: index_valid, window_closed
// cfg_*    in         cfg_wen              cfg_wdata: window_interval_ms
//
// A sample that stays inside its window, or closes an empty one, has its result
// loaded into the result register once the back part reaches it and that register is free.
// A sample closing a window with samples steps the back through average divide, AC, DC,
// multiply, index divide (skipped for zero DC) and emit, on the one shared divider.
// The front keeps taking samples while the two-entry request queue has room.
// Reset clears window state, latched statistics and the interval (back to 1000 ms).
module windowed_pulse_perfusion_stats #(
	parameter int unsigned FRACTION_BITS = wpps_pkg::FRACTION_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Window interval register.
	input  logic                           cfg_wen,
	input  logic [wpps_pkg::TIME_W-1:0]    cfg_wdata,
	// Sample stream.
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [wpps_pkg::S_DATA_W-1:0]  s_tdata,   // sample[15:0], timestamp_ms[47:16]
	// Result stream.
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [wpps_pkg::M_DATA_W-1:0]  m_tdata,   // window_average[23:0],
	                                                  // window_peak[39:24], ac_part[64:40],
	                                                  // dc_part[91:65],
	                                                  // perfusion_index[123:92], zero[127:124]
	output logic [wpps_pkg::M_USER_W-1:0]  m_tuser    // index_valid[0], window_closed[1]
);
	import wpps_pkg::*;

	// Request path from front to back.
	logic push;
	cmd_t push_cmd;
	logic q_full;
	logic q_valid;
	cmd_t q_head;
	logic pop;

	// Front: tracks the open window, classifies each sample as accumulate,
	// close-empty or close-and-latch, and posts one request per sample.
	wpps_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.push      (push),
		.push_cmd  (push_cmd),
		.q_full    (q_full)
	);

	// Queue: decouple the front from the divider latency in the back.
	wpps_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.valid    (q_valid),
		.head     (q_head)
	);

	// Back: on a latch request, divide for the average, derive AC and DC and, unless DC is
	// zero, divide again for the index; every request then drives the result register.
	wpps_back #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

[design/wpps_queue.sv]
// Short request queue between the front and the back.
`timescale 1ns / 1ps

module wpps_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  wpps_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          valid,
	output wpps_pkg::cmd_t head
);
	import wpps_pkg::*;

	localparam int unsigned PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;

	assign full  = (fill_q == FILL_W'(QUEUE_DEPTH));
	assign valid = (fill_q != '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

[design/wpps_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module wpps_div #(
	parameter int unsigned DW = 40,
	parameter int unsigned VW = 27
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);
	localparam int unsigned CW = $clog2(DW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] quo_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dsr_q;

	logic [VW:0] rem_sh;
	logic        fits;
	logic [VW:0] rem_nx;

	always_comb begin
		rem_sh = {rem_q, quo_q[DW-1]};
		fits   = (rem_sh >= {1'b0, dsr_q});
		rem_nx = fits ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
	end

	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], fits};
			rem_q <= rem_nx[VW-1:0];
		end
	end

endmodule

[design/wpps_front.sv]
// Front part: takes samples, keeps the open window and issues requests.
`timescale 1ns / 1ps

module wpps_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [wpps_pkg::TIME_W-1:0]    cfg_wdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [wpps_pkg::S_DATA_W-1:0]  s_tdata,
	output logic                           push,
	output wpps_pkg::cmd_t                 push_cmd,
	input  logic                           q_full
);
	import wpps_pkg::*;

	logic [TIME_W-1:0]   interval_q;
	logic [TIME_W-1:0]   win_start_q;
	logic [SUM_W-1:0]    sum_q;
	logic [COUNT_W-1:0]  count_q;
	logic [PEAK_W-1:0]   max_q;

	logic [SAMPLE_W-1:0] sample;
	logic [TIME_W-1:0]   stamp;
	logic [TIME_W-1:0]   elapsed;
	logic                in_win;
	logic                accept;

	always_comb begin
		sample   = s_tdata[SAMPLE_W-1:0];
		stamp    = s_tdata[SAMPLE_W +: TIME_W];
		elapsed  = stamp - win_start_q;
		in_win   = (elapsed <= interval_q);
		s_tready = !q_full;
		accept   = s_tvalid && !q_full;

		push              = accept;
		push_cmd.closed   = !in_win;
		push_cmd.latch    = !in_win && (count_q != '0);
		push_cmd.sum      = sum_q;
		push_cmd.count    = count_q;
		push_cmd.peak     = max_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q  <= INTERVAL_RESET;
			win_start_q <= '0;
			sum_q       <= '0;
			count_q     <= '0;
			max_q       <= '0;
		end else begin
			if (cfg_wen) begin
				interval_q <= cfg_wdata;
			end
			if (accept) begin
				if (in_win) begin
					if (count_q < MAX_SAMPLES_PER_WINDOW) begin
						sum_q   <= sum_q + SUM_W'(sample);
						count_q <= count_q + COUNT_W'(1);
					end
					if (sample > max_q) begin
						max_q <= sample;
					end
				end else begin
					win_start_q <= stamp;
					if (count_q != '0) begin
						sum_q   <= '0;
						count_q <= '0;
						max_q   <= '0;
					end
				end
			end
		end
	end

endmodule

[design/wpps_back.sv]
// Back part: latches window statistics and drives the result register.
`timescale 1ns / 1ps

module wpps_back #(
	parameter int unsigned FRACTION_BITS = wpps_pkg::FRACTION_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	input  wpps_pkg::cmd_t                 q_head,
	output logic                           pop,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [wpps_pkg::M_DATA_W-1:0]  m_tdata,
	output logic [wpps_pkg::M_USER_W-1:0]  m_tuser
);
	import wpps_pkg::*;

	localparam int unsigned DW = SUM_W + FRACTION_BITS;
	localparam int unsigned AW = 28 + FRACTION_BITS;

	localparam logic signed [AW-1:0] AC_HI = AW'(AC_MAX);
	localparam logic signed [AW-1:0] DC_HI = AW'(DC_MAX);
	localparam logic signed [AW-1:0] DC_LO = AW'(DC_MIN);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AVG,
		ST_AC,
		ST_DC,
		ST_MUL,
		ST_PI_LOAD,
		ST_PI,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic [AVG_W-1:0]    avg_q;
	logic [PEAK_W-1:0]   peak_q;
	logic [AC_W-1:0]     ac_q;
	logic [DC_W-1:0]     dc_q;
	logic [PI_W-1:0]     pi_q;
	logic                valid_q;
	logic                closed_q;
	logic                dc_neg_q;
	logic [PI_W-1:0]     num_q;
	logic                div_start_q;
	logic [DW-1:0]       div_dividend_q;
	logic [DC_W-1:0]     div_divisor_q;
	logic                m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;
	logic [M_USER_W-1:0] m_tuser_q;

	logic                div_done;
	logic [DW-1:0]       div_quo;

	logic                out_free;
	logic                emit;
	logic                div_go;
	logic signed [AW-1:0] peak_w;
	logic signed [AW-1:0] ac_raw;
	logic signed [AW-1:0] dc_raw;
	logic [AC_W-1:0]     ac_clamp;
	logic [DC_W-1:0]     dc_clamp;
	logic [AVG_W-1:0]    avg_sat;
	logic [PI_W-1:0]     pi_mag;
	logic [PI_W-1:0]     pi_val;
	logic [DC_W-1:0]     dc_abs;
	logic [M_DATA_W-1:0] res_data;

	wpps_div #(
		.DW(DW),
		.VW(DC_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_dividend_q),
		.divisor  (div_divisor_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		out_free = !m_tvalid_q || m_tready;
		pop      = (state_q == ST_IDLE) && q_valid && (q_head.latch || out_free);
		emit     = ((state_q == ST_IDLE) && q_valid && !q_head.latch && out_free) ||
			((state_q == ST_EMIT) && out_free);
		div_go   = ((state_q == ST_IDLE) && q_valid && q_head.latch) ||
			(state_q == ST_PI_LOAD);

		peak_w = AW'(peak_q) << FRACTION_BITS;
		ac_raw = (peak_w - AW'(avg_q)) << 1;
		dc_raw = (peak_w - AW'(ac_q)) << 1;

		if (ac_raw < 0) begin
			ac_clamp = '0;
		end else if (ac_raw > AC_HI) begin
			ac_clamp = AC_HI[AC_W-1:0];
		end else begin
			ac_clamp = ac_raw[AC_W-1:0];
		end

		if (dc_raw < DC_LO) begin
			dc_clamp = DC_LO[DC_W-1:0];
		end else if (dc_raw > DC_HI) begin
			dc_clamp = DC_HI[DC_W-1:0];
		end else begin
			dc_clamp = dc_raw[DC_W-1:0];
		end

		avg_sat = (|div_quo[DW-1:AVG_W]) ? AVG_MAX : div_quo[AVG_W-1:0];
		pi_mag  = (|div_quo[DW-1:PI_W-1]) ? PI_MAX : {1'b0, div_quo[PI_W-2:0]};
		pi_val  = dc_neg_q ? (~pi_mag + PI_W'(1)) : pi_mag;
		dc_abs  = dc_q[DC_W-1] ? (~dc_q + DC_W'(1)) : dc_q;

		res_data = M_DATA_W'({pi_q, dc_q, ac_q, peak_q, avg_q});
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			avg_q          <= '0;
			peak_q         <= '0;
			ac_q           <= '0;
			dc_q           <= '0;
			pi_q           <= '0;
			valid_q        <= 1'b0;
			closed_q       <= 1'b0;
			dc_neg_q       <= 1'b0;
			num_q          <= '0;
			div_start_q    <= 1'b0;
			div_dividend_q <= '0;
			div_divisor_q  <= '0;
			m_tvalid_q     <= 1'b0;
			m_tdata_q      <= '0;
			m_tuser_q      <= '0;
		end else begin
			div_start_q <= div_go;
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						if (q_head.latch) begin
							peak_q         <= q_head.peak;
							closed_q       <= q_head.closed;
							div_dividend_q <= DW'(q_head.sum) << FRACTION_BITS;
							div_divisor_q  <= DC_W'(q_head.count);
							state_q        <= ST_AVG;
						end else if (out_free) begin
							m_tdata_q                  <= res_data;
							m_tuser_q[USER_VALID_BIT]  <= valid_q;
							m_tuser_q[USER_CLOSED_BIT] <= q_head.closed;
						end
					end
				end
				ST_AVG: begin
					if (div_done) begin
						avg_q   <= avg_sat;
						state_q <= ST_AC;
					end
				end
				ST_AC: begin
					ac_q    <= ac_clamp;
					state_q <= ST_DC;
				end
				ST_DC: begin
					dc_q    <= dc_clamp;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					valid_q       <= (dc_q != '0);
					dc_neg_q      <= dc_q[DC_W-1];
					num_q         <= PI_W'(ac_q) * PI_SCALE;
					div_divisor_q <= dc_abs;
					if (dc_q == '0) begin
						pi_q    <= (ac_q != '0) ? PI_MAX : '0;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_PI_LOAD;
					end
				end
				ST_PI_LOAD: begin
					div_dividend_q <= DW'(num_q) << FRACTION_BITS;
					state_q        <= ST_PI;
				end
				ST_PI: begin
					if (div_done) begin
						pi_q    <= pi_val;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						m_tdata_q                  <= res_data;
						m_tuser_q[USER_VALID_BIT]  <= valid_q;
						m_tuser_q[USER_CLOSED_BIT] <= closed_q;
						state_q                    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[design/wpps_checker.sv]
// Port-level checks of the windowed perfusion statistics block.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wpps_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [wpps_pkg::M_DATA_W-1:0]  m_tdata,
	input logic [wpps_pkg::M_USER_W-1:0]  m_tuser
);
	import wpps_pkg::*;

	`WPPS_ASSERT_ALWAYS(a_idle_in_reset, !arst_n |-> !m_tvalid, "result shown during reset")

	`WPPS_ASSERT(a_dc_zero_invalid, m_tvalid |-> ((m_tdata[91:65] == 27'd0) == !m_tuser[0]), "index_valid does not match dc_part")

	`WPPS_ASSERT(a_invalid_index_code, (m_tvalid && !m_tuser[0]) |-> (m_tdata[123:92] == 32'h0 || m_tdata[123:92] == 32'h7FFF_FFFF), "bad index for zero dc_part")

	`WPPS_ASSERT(a_index_range, m_tvalid |-> (m_tdata[123:92] != 32'h8000_0000), "index outside saturation range")

	`WPPS_ASSERT(a_hold_stalled, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "stalled result changed")

endmodule

bind windowed_pulse_perfusion_stats wpps_checker u_wpps_checker (.*);
